### hw/rtl/lef_pkg.sv
// Package for the LED effect fader: payload structs, step table entry,
// operation codes, controller states and the control/status bundles.
// Depends on nothing; every other file of the block imports it.
package lef_pkg;

    localparam int MAX_STEPS_DEF = 16;
    localparam int CHANNELS_DEF  = 3;

    localparam int LVL_W     = 8;
    localparam int SUB_W     = 16;
    localparam int LEN_W     = 5;
    localparam int IDX_W     = 4;
    localparam int MAX_CH    = 4;
    localparam int OUT_CH    = 3;
    localparam int DIV_STEPS = LVL_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [IDX_W-1:0]   step_index;
        logic [LVL_W-1:0]   step_red;
        logic [LVL_W-1:0]   step_green;
        logic [LVL_W-1:0]   step_blue;
        logic [SUB_W-1:0]   step_substeps;
        logic [SUB_W-1:0]   step_delay_ms;
        logic [LEN_W-1:0]   effect_length;
        logic               repeat_forever;
    } in_t;

    typedef struct packed {
        logic [LVL_W-1:0] level_red;
        logic [LVL_W-1:0] level_green;
        logic [LVL_W-1:0] level_blue;
        logic             pin_red;
        logic             pin_green;
        logic             pin_blue;
        logic             effect_finished;
    } out_t;

    typedef struct packed {
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
        logic [SUB_W-1:0] substeps;
        logic [SUB_W-1:0] delay;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT,
        ST_FETCH,
        ST_ARM
    } state_t;

    typedef struct packed {
        logic accept;
        logic setup;
        logic load;
        logic step;
        logic update;
        logic emit;
        logic arm;
    } cmd_t;

    typedef struct packed {
        logic fire;
        logic start_run;
        logic div_last;
        logic last_chan;
        logic out_free;
        logic keep_running;
    } sts_t;

endpackage

### hw/rtl/led_effect_fader.sv
// LED effect fader: plays a color fade from a table of steps, one update per
// expired substep delay. A write, stop, idle tick or tick that does not expire
// the delay is handled in the idle state alone. A start also passes through
// fetch and arm, since the first step's delay comes through the table's
// registered read port. A tick that expires the delay runs setup, then load,
// the shared 8-step restoring divider and update for each channel in turn,
// then emit, which waits for the result register to be free, and then fetch
// and arm unless it ends the effect.
// A finished result waits in its own register, so new items are taken while
// it is pending. Depends on lef_pkg, lef_ctrl and lef_datapath.
module led_effect_fader import lef_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int CHANNELS  = CHANNELS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    cmd_t cmd;
    sts_t sts;

    lef_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lef_datapath #(
        .MAX_STEPS (MAX_STEPS),
        .CHANNELS  (CHANNELS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

### hw/rtl/lef_ctrl.sv
// Controller state machine of the LED effect fader.
// Sequences transfers, the per-channel divide and the step table reads.
// Depends on lef_pkg.
module lef_ctrl import lef_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (sts.fire) begin
                        state_next = ST_SETUP;
                    end else if (sts.start_run) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_SETUP:  state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_DIV;
            ST_DIV: begin
                if (sts.div_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = sts.last_chan ? ST_EMIT : ST_LOAD;
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = sts.keep_running ? ST_FETCH : ST_IDLE;
                end
            end
            ST_FETCH:  state_next = ST_ARM;
            ST_ARM:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_SETUP:  cmd.setup  = 1'b1;
            ST_LOAD:   cmd.load   = 1'b1;
            ST_DIV:    cmd.step   = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_EMIT:   cmd.emit   = sts.out_free;
            ST_ARM:    cmd.arm    = 1'b1;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/lef_datapath.sv
// Datapath of the LED effect fader: step table memory, effect state,
// shared restoring divider, level update and the result register.
// Depends on lef_pkg; driven by lef_ctrl through cmd_t and sts_t.
module lef_datapath import lef_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int CHANNELS  = CHANNELS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data,
    input  cmd_t cmd,
    output sts_t sts
);

    localparam int TIDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    entry_t step_mem [MAX_STEPS];
    entry_t rd_data_reg;

    logic               run_reg,   run_next;
    logic [LEN_W-1:0]   step_reg,  step_next;
    logic [LEN_W-1:0]   len_reg,   len_next;
    logic               rep_reg,   rep_next;
    logic [SUB_W-1:0]   sub_reg,   sub_next;
    logic [SUB_W-1:0]   delay_reg, delay_next;
    logic [SUB_W-1:0]   subs_reg,  subs_next;
    logic [SUB_W-1:0]   left_reg,  left_next;
    logic [SUB_W-1:0]   rem_reg,   rem_next;
    logic [LVL_W-1:0]   quo_reg,   quo_next;
    logic               neg_reg,   neg_next;
    logic [DCNT_W-1:0]  cnt_reg,   cnt_next;
    logic [CH_W-1:0]    ch_reg,    ch_next;
    logic [LVL_W-1:0]   lvl_reg [CHANNELS];
    logic [LVL_W-1:0]   lvl_next [CHANNELS];
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg,  m_data_next;

    logic [SUB_W-1:0]   delay_dec;
    logic [LEN_W-1:0]   len_sat;
    logic               wr_en;
    logic [LVL_W-1:0]   tgt [MAX_CH];
    logic [LVL_W-1:0]   cur_lvl;
    logic [LVL_W-1:0]   cur_tgt;
    logic [SUB_W-1:0]   subs_eff;
    logic [SUB_W-1:0]   left_calc;
    logic [LVL_W:0]     diff;
    logic [LVL_W-1:0]   mag;
    logic [SUB_W:0]     rem_sh;
    logic [SUB_W:0]     rem_sub;
    logic               div_ge;
    logic [LVL_W:0]     qx;
    logic [LVL_W:0]     lvl_sum;
    logic [SUB_W:0]     sub_inc;
    logic               wrap;
    logic [LEN_W-1:0]   step_inc;
    logic               end_run;
    logic [LEN_W-1:0]   step_fin;
    logic               finished;
    logic               keep;
    logic [LVL_W-1:0]   lvl_pad [OUT_CH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            step_mem[TIDX_W'(s_data.step_index)] <= '{
                red:      s_data.step_red,
                green:    s_data.step_green,
                blue:     s_data.step_blue,
                substeps: s_data.step_substeps,
                delay:    s_data.step_delay_ms
            };
        end
        rd_data_reg <= step_mem[TIDX_W'(step_reg)];
    end

    always_comb begin
        delay_dec = (delay_reg != '0) ? delay_reg - SUB_W'(1) : '0;
        len_sat   = (int'(s_data.effect_length) > MAX_STEPS) ? LEN_W'(MAX_STEPS)
                                                             : s_data.effect_length;
        wr_en     = cmd.accept && (s_data.operation == OP_WRITE)
                    && (int'(s_data.step_index) < MAX_STEPS);

        tgt[0]    = rd_data_reg.red;
        tgt[1]    = rd_data_reg.green;
        tgt[2]    = rd_data_reg.blue;
        tgt[3]    = '0;
        cur_lvl   = lvl_reg[ch_reg];
        cur_tgt   = tgt[ch_reg];

        subs_eff  = (rd_data_reg.substeps == '0) ? SUB_W'(1) : rd_data_reg.substeps;
        left_calc = (sub_reg < subs_eff) ? subs_eff - sub_reg : SUB_W'(1);

        diff      = {1'b0, cur_tgt} - {1'b0, cur_lvl};
        mag       = diff[LVL_W] ? LVL_W'(-diff) : diff[LVL_W-1:0];

        rem_sh    = {rem_reg, quo_reg[LVL_W-1]};
        div_ge    = rem_sh >= {1'b0, left_reg};
        rem_sub   = rem_sh - {1'b0, left_reg};

        qx        = {1'b0, quo_reg};
        lvl_sum   = {1'b0, cur_lvl} + (neg_reg ? -qx : qx);

        sub_inc   = {1'b0, sub_reg} + (SUB_W+1)'(1);
        wrap      = sub_inc >= {1'b0, subs_reg};
        step_inc  = step_reg + LEN_W'(1);
        end_run   = wrap && (step_inc >= len_reg);
        if (!wrap) begin
            step_fin = step_reg;
        end else if (end_run && rep_reg) begin
            step_fin = '0;
        end else begin
            step_fin = step_inc;
        end
        finished  = end_run && !rep_reg;
        keep      = step_fin < len_reg;

        for (int c = 0; c < OUT_CH; c++) begin
            lvl_pad[c] = '0;
        end
        for (int c = 0; c < CHANNELS && c < OUT_CH; c++) begin
            lvl_pad[c] = lvl_reg[c];
        end
    end

    always_comb begin
        run_next     = run_reg;
        step_next    = step_reg;
        len_next     = len_reg;
        rep_next     = rep_reg;
        sub_next     = sub_reg;
        delay_next   = delay_reg;
        subs_next    = subs_reg;
        left_next    = left_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        ch_next      = ch_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        for (int c = 0; c < CHANNELS; c++) begin
            lvl_next[c] = lvl_reg[c];
        end

        if (cmd.accept) begin
            case (s_data.operation)
                OP_TICK: begin
                    if (run_reg) begin
                        delay_next = delay_dec;
                    end
                end
                OP_START: begin
                    len_next   = len_sat;
                    rep_next   = s_data.repeat_forever;
                    step_next  = '0;
                    sub_next   = '0;
                    run_next   = (len_sat != '0);
                    delay_next = '0;
                end
                OP_STOP: begin
                    run_next   = 1'b0;
                    delay_next = '0;
                end
                default: begin
                    run_next = run_reg;
                end
            endcase
        end

        if (cmd.setup) begin
            subs_next = subs_eff;
            left_next = left_calc;
            ch_next   = '0;
        end

        if (cmd.load) begin
            rem_next = '0;
            quo_next = mag;
            neg_next = diff[LVL_W];
            cnt_next = DCNT_W'(DIV_STEPS);
        end

        if (cmd.step) begin
            rem_next = div_ge ? rem_sub[SUB_W-1:0] : rem_sh[SUB_W-1:0];
            quo_next = {quo_reg[LVL_W-2:0], div_ge};
            cnt_next = cnt_reg - DCNT_W'(1);
        end

        if (cmd.update) begin
            lvl_next[ch_reg] = lvl_sum[LVL_W-1:0];
            if (ch_reg != CH_W'(CHANNELS - 1)) begin
                ch_next = ch_reg + CH_W'(1);
            end
        end

        if (cmd.emit) begin
            m_valid_next                = 1'b1;
            m_data_next.level_red       = lvl_pad[0];
            m_data_next.level_green     = lvl_pad[1];
            m_data_next.level_blue      = lvl_pad[2];
            m_data_next.pin_red         = (lvl_pad[0] != '0);
            m_data_next.pin_green       = (lvl_pad[1] != '0);
            m_data_next.pin_blue        = (lvl_pad[2] != '0);
            m_data_next.effect_finished = finished;
            sub_next  = wrap ? '0 : sub_inc[SUB_W-1:0];
            step_next = step_fin;
            run_next  = keep;
            if (!keep) begin
                delay_next = '0;
            end
        end

        if (cmd.arm) begin
            delay_next = rd_data_reg.delay;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            step_reg    <= '0;
            len_reg     <= '0;
            rep_reg     <= 1'b0;
            sub_reg     <= '0;
            delay_reg   <= '0;
            cnt_reg     <= '0;
            ch_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                lvl_reg[c] <= '0;
            end
        end else begin
            run_reg     <= run_next;
            step_reg    <= step_next;
            len_reg     <= len_next;
            rep_reg     <= rep_next;
            sub_reg     <= sub_next;
            delay_reg   <= delay_next;
            cnt_reg     <= cnt_next;
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
            for (int c = 0; c < CHANNELS; c++) begin
                lvl_reg[c] <= lvl_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        subs_reg   <= subs_next;
        left_reg   <= left_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        sts.fire         = (s_data.operation == OP_TICK) && run_reg && (delay_dec == '0);
        sts.start_run    = (s_data.operation == OP_START) && (len_sat != '0);
        sts.div_last     = (cnt_reg == DCNT_W'(1));
        sts.last_chan    = (ch_reg == CH_W'(CHANNELS - 1));
        sts.out_free     = !m_valid_reg || m_ready;
        sts.keep_running = keep;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
